/* design/rhsn_pkg.sv */
// Shared types and constants for the ray hit point and surface normal pipeline.
package rhsn_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned SQRT_STEPS    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_ORIGIN_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_SPHERE  = 3'd1,
		KIND_PLANE   = 3'd2,
		KIND_CYL     = 3'd3,
		KIND_CYL_ALT = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0]        distance;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
	} hit_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic               type_known;
	} res_t;

	// Per-request flags and pass-through data that ride alongside the arithmetic.
	typedef struct packed {
		logic             known;
		logic             plane;
		logic             radial;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] axis;
	} side_t;

	// Tag carried through the square root and divide stages.
	typedef struct packed {
		logic [2:0][29:0] m;
		logic [2:0]       neg;
		logic             zero;
		side_t            side;
	} norm_tag_t;

endpackage

/* design/rhsn_pos.sv */
// Hit point stages: P = O + D*t saturated, and V = P - C.
module rhsn_pos #(
	parameter int unsigned FracBits = rhsn_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rhsn_pkg::hit_t      hit,
	input  logic [2:0][31:0]    origin,
	output logic                out_valid,
	output logic [2:0][32:0]    vec,
	output rhsn_pkg::side_t     side
);

	localparam logic signed [63:0] SatHi = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SatLo = -64'sh0000_0000_8000_0000;

	logic [2:0][31:0] dir, dmag, cen, axis;
	logic             known, radial, plane;

	logic             valid_s1;
	logic [2:0][61:0] prod_s1;
	logic [2:0]       neg_s1;
	logic [2:0][31:0] cen_s1;
	rhsn_pkg::side_t  side_s1;

	logic [2:0][31:0] p_c;
	logic [2:0][32:0] v_c;

	logic             valid_s2;
	logic [2:0][32:0] vec_s2;
	rhsn_pkg::side_t  side_s2;

	assign dir  = {hit.dir_z, hit.dir_y, hit.dir_x};
	assign cen  = {hit.center_z, hit.center_y, hit.center_x};
	assign axis = {hit.axis_z, hit.axis_y, hit.axis_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = dir[i][31] ? (~dir[i] + 32'd1) : dir[i];
		end
	end

	always_comb begin
		known  = 1'b0;
		plane  = 1'b0;
		radial = 1'b0;
		unique case (hit.kind)
			rhsn_pkg::KIND_SPHERE: begin
				known = 1'b1;
			end
			rhsn_pkg::KIND_PLANE: begin
				known = 1'b1;
				plane = 1'b1;
			end
			rhsn_pkg::KIND_CYL, rhsn_pkg::KIND_CYL_ALT: begin
				known  = 1'b1;
				radial = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= 62'(dmag[i]) * 62'(hit.distance);
			neg_s1[i]  <= dir[i][31];
		end
		cen_s1         <= cen;
		side_s1.known  <= known;
		side_s1.plane  <= plane;
		side_s1.radial <= radial;
		side_s1.pos    <= '0;
		side_s1.axis   <= axis;
	end

	always_comb begin
		logic [63:0] ext;
		logic [63:0] sum;
		ext = '0;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			ext = {2'b00, prod_s1[i] >> FracBits};
			if (neg_s1[i]) begin
				ext = 64'd0 - ext;
			end
			sum = {{32{origin[i][31]}}, origin[i]} + ext;
			if ($signed(sum) > SatHi) begin
				p_c[i] = 32'h7FFF_FFFF;
			end else if ($signed(sum) < SatLo) begin
				p_c[i] = 32'h8000_0000;
			end else begin
				p_c[i] = sum[31:0];
			end
			v_c[i] = {p_c[i][31], p_c[i]} - {cen_s1[i][31], cen_s1[i]};
		end
	end

	always_ff @(posedge clk) begin
		vec_s2  <= v_c;
		side_s2 <= '{known: side_s1.known, plane: side_s1.plane,
			radial: side_s1.radial, pos: p_c, axis: side_s1.axis};
	end

	assign out_valid = valid_s2;
	assign vec       = vec_s2;
	assign side      = side_s2;

endmodule

/* design/rhsn_radial.sv */
// Radial part for cylinders: W = V - A*dot(V, A); all other kinds pass V through.
module rhsn_radial #(
	parameter int unsigned FracBits = rhsn_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2:0][32:0]    vec,
	input  rhsn_pkg::side_t     side,
	output logic                out_valid,
	output logic [2:0][63:0]    wvec,
	output rhsn_pkg::side_t     side_out
);

	localparam logic signed [65:0] SatHi = 66'sd2147483647;
	localparam logic signed [65:0] SatLo = -66'sd2147483648;

	logic [2:0][32:0] vmag;
	logic [2:0][31:0] amag_in;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0][63:0] prod_s1;
	logic [2:0]       neg_s1;
	logic [2:0][32:0] vec_s1, vec_s2, vec_s3;
	rhsn_pkg::side_t  side_s1, side_s2, side_s3, side_s4;

	logic [31:0]      dot_c;
	logic [31:0]      dot_s2;

	logic [2:0][31:0] amag_s2;
	logic [31:0]      smag;
	logic [2:0][63:0] prod_s3;
	logic [2:0]       neg_s3;

	logic [2:0][63:0] w_c;
	logic [2:0][63:0] w_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vmag[i]    = vec[i][32] ? (~vec[i] + 33'd1) : vec[i];
			amag_in[i] = side.axis[i][31] ? (~side.axis[i] + 32'd1) : side.axis[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= 64'(vmag[i]) * 64'(amag_in[i]);
			neg_s1[i]  <= vec[i][32] ^ side.axis[i][31];
		end
		vec_s1  <= vec;
		side_s1 <= side;
	end

	// Sum the three truncated products, then saturate the dot product.
	always_comb begin
		logic [65:0] ext;
		logic [65:0] sum;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			ext = {2'b00, prod_s1[i] >> FracBits};
			if (neg_s1[i]) begin
				ext = 66'd0 - ext;
			end
			sum = sum + ext;
		end
		if ($signed(sum) > SatHi) begin
			dot_c = 32'h7FFF_FFFF;
		end else if ($signed(sum) < SatLo) begin
			dot_c = 32'h8000_0000;
		end else begin
			dot_c = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		dot_s2  <= dot_c;
		vec_s2  <= vec_s1;
		side_s2 <= side_s1;
		for (int i = 0; i < 3; i++) begin
			amag_s2[i] <= side_s1.axis[i][31] ? (~side_s1.axis[i] + 32'd1) : side_s1.axis[i];
		end
	end

	assign smag = dot_s2[31] ? (~dot_s2 + 32'd1) : dot_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s3[i] <= 64'(amag_s2[i]) * 64'(smag);
			neg_s3[i]  <= side_s2.axis[i][31] ^ dot_s2[31];
		end
		vec_s3  <= vec_s2;
		side_s3 <= side_s2;
	end

	always_comb begin
		logic [63:0] ext;
		logic [63:0] vx;
		ext = '0;
		vx  = '0;
		for (int i = 0; i < 3; i++) begin
			ext = prod_s3[i] >> FracBits;
			if (neg_s3[i]) begin
				ext = 64'd0 - ext;
			end
			vx = {{31{vec_s3[i][32]}}, vec_s3[i]};
			w_c[i] = side_s3.radial ? (vx - ext) : vx;
		end
	end

	always_ff @(posedge clk) begin
		w_s4    <= w_c;
		side_s4 <= side_s3;
	end

	assign out_valid = valid_s4;
	assign wvec      = w_s4;
	assign side_out  = side_s4;

endmodule

/* design/rhsn_norm.sv */
// Normaliser: common power-of-two scaling, pipelined integer square root and divide.
module rhsn_norm #(
	parameter int unsigned FracBits = rhsn_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2:0][63:0]    wvec,
	input  rhsn_pkg::side_t     side,
	output logic                out_valid,
	output logic [2:0][31:0]    norm,
	output rhsn_pkg::side_t     side_out
);

	localparam int unsigned Steps = rhsn_pkg::SQRT_STEPS;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0][63:0] mag_s1, mag_s2;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]      any_s1;
	rhsn_pkg::side_t  side_s1, side_s2, side_s3, side_s4;

	logic [5:0]       lead_c;
	logic [5:0]       lead_s2;
	logic             zero_s2, zero_s3, zero_s4;

	logic [2:0][29:0] m_c;
	logic [2:0][29:0] m_s3, m_s4;
	logic [2:0][59:0] sq_s4;

	logic                  rt_v_sn   [0:Steps];
	logic [63:0]           rt_x_sn   [0:Steps];
	logic [63:0]           rt_r_sn   [0:Steps];
	rhsn_pkg::norm_tag_t   rt_tag_sn [0:Steps];

	logic                     dv_v_sn   [0:FracBits];
	logic [2:0][31:0]         dv_rem_sn [0:FracBits];
	logic [2:0][FracBits:0]   dv_q_sn   [0:FracBits];
	logic [31:0]              dv_len_sn [0:FracBits];
	rhsn_pkg::norm_tag_t      dv_tag_sn [0:FracBits];

	logic             valid_out_q;
	logic [2:0][31:0] norm_q;
	rhsn_pkg::side_t  side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			rt_v_sn[0] <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			rt_v_sn[0] <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [2:0][63:0] mg;
		for (int i = 0; i < 3; i++) begin
			mg[i] = wvec[i][63] ? (~wvec[i] + 64'd1) : wvec[i];
		end
		mag_s1  <= mg;
		any_s1  <= mg[0] | mg[1] | mg[2];
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= wvec[i][63];
		end
		side_s1 <= side;
	end

	// Find the leading one of the largest magnitude.
	always_comb begin
		lead_c = '0;
		for (int b = 0; b < 64; b++) begin
			if (any_s1[b]) begin
				lead_c = 6'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		lead_s2 <= lead_c;
		zero_s2 <= (any_s1 == 64'd0);
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		side_s2 <= side_s1;
	end

	// Bring the largest magnitude into [2^29, 2^30).
	always_comb begin
		logic [63:0] sh;
		sh = '0;
		for (int i = 0; i < 3; i++) begin
			if (lead_s2 >= 6'd30) begin
				sh = mag_s2[i] >> (lead_s2 - 6'd29);
			end else begin
				sh = mag_s2[i] << (6'd29 - lead_s2);
			end
			m_c[i] = sh[29:0];
		end
	end

	always_ff @(posedge clk) begin
		m_s3    <= m_c;
		zero_s3 <= zero_s2;
		neg_s3  <= neg_s2;
		side_s3 <= side_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= 60'(m_s3[i]) * 60'(m_s3[i]);
		end
		m_s4    <= m_s3;
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
		side_s4 <= side_s3;
	end

	always_ff @(posedge clk) begin
		rt_x_sn[0]   <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
		rt_r_sn[0]   <= '0;
		rt_tag_sn[0] <= '{m: m_s4, neg: neg_s4, zero: zero_s4, side: side_s4};
	end

	// One result bit of the integer square root per stage.
	for (genvar j = 0; j < Steps; j++) begin : g_sqrt
		localparam logic [63:0] BitVal = 64'd1 << (62 - 2 * j);
		logic [63:0] trial;
		logic        take;

		assign trial = rt_r_sn[j] + BitVal;
		assign take  = (rt_x_sn[j] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_sn[j+1] <= 1'b0;
			end else begin
				rt_v_sn[j+1] <= rt_v_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			rt_x_sn[j+1]   <= take ? (rt_x_sn[j] - trial) : rt_x_sn[j];
			rt_r_sn[j+1]   <= take ? ((rt_r_sn[j] >> 1) + BitVal) : (rt_r_sn[j] >> 1);
			rt_tag_sn[j+1] <= rt_tag_sn[j];
		end
	end

	// Integer part of the quotient: each magnitude is at most the length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_sn[0] <= 1'b0;
		end else begin
			dv_v_sn[0] <= rt_v_sn[Steps];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] len;
		logic [31:0] mm;
		len = rt_r_sn[Steps][31:0];
		for (int i = 0; i < 3; i++) begin
			mm = {2'b00, rt_tag_sn[Steps].m[i]};
			if (mm >= len) begin
				dv_rem_sn[0][i] <= mm - len;
				dv_q_sn[0][i]   <= (FracBits + 1)'(1);
			end else begin
				dv_rem_sn[0][i] <= mm;
				dv_q_sn[0][i]   <= '0;
			end
		end
		dv_len_sn[0] <= len;
		dv_tag_sn[0] <= rt_tag_sn[Steps];
	end

	// One fraction bit of the quotient per stage.
	for (genvar k = 0; k < FracBits; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_sn[k+1] <= 1'b0;
			end else begin
				dv_v_sn[k+1] <= dv_v_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [32:0] r2;
			for (int i = 0; i < 3; i++) begin
				r2 = {dv_rem_sn[k][i], 1'b0};
				if (r2 >= {1'b0, dv_len_sn[k]}) begin
					dv_rem_sn[k+1][i] <= 32'(r2 - {1'b0, dv_len_sn[k]});
					dv_q_sn[k+1][i]   <= {dv_q_sn[k][i][FracBits-1:0], 1'b1};
				end else begin
					dv_rem_sn[k+1][i] <= r2[31:0];
					dv_q_sn[k+1][i]   <= {dv_q_sn[k][i][FracBits-1:0], 1'b0};
				end
			end
			dv_len_sn[k+1] <= dv_len_sn[k];
			dv_tag_sn[k+1] <= dv_tag_sn[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else begin
			valid_out_q <= dv_v_sn[FracBits];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] q;
		for (int i = 0; i < 3; i++) begin
			q = 32'(dv_q_sn[FracBits][i]);
			if (dv_tag_sn[FracBits].zero) begin
				norm_q[i] <= '0;
			end else if (dv_tag_sn[FracBits].neg[i]) begin
				norm_q[i] <= 32'd0 - q;
			end else begin
				norm_q[i] <= q;
			end
		end
		side_q <= dv_tag_sn[FracBits].side;
	end

	assign out_valid = valid_out_q;
	assign norm      = norm_q;
	assign side_out  = side_q;

endmodule

/* design/ray_hit_surface_normal.sv */
// Top level: ray hit point and unit surface normal, fully pipelined.
//
// Each request carries one ray hit (object kind, ray direction, hit distance,
// object centre and plane normal or cylinder axis); the ray origin is held in
// three configuration registers (origin_x, origin_y, origin_z at indexes 0 to 2,
// reset to zero, an index of 3 is dropped). A request is taken on every clock
// edge where start is high; busy is always low, so one request per cycle is
// sustained. Each result appears on res for exactly one cycle with done high,
// in request order. The receiver cannot hold results off and none is needed:
// the pipeline never stalls. The square root resolves one result bit per stage
// over 32 stages, and the divide one quotient bit per stage. All values are
// signed fixed point with FracBits fraction bits (Q16.16 by default); the hit
// point saturates to 32 bits. Unknown kinds return all zeros with type_known low.
// Write the origin only while no request is in flight.
module ray_hit_surface_normal #(
	parameter int unsigned FracBits = rhsn_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rhsn_pkg::hit_t                    hit,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rhsn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	output logic                              done,
	output rhsn_pkg::res_t                    res
);

	logic [31:0]      origin_x_q, origin_y_q, origin_z_q;
	logic             accept;

	logic             pos_valid;
	logic [2:0][32:0] pos_vec;
	rhsn_pkg::side_t  pos_side;

	logic             rad_valid;
	logic [2:0][63:0] rad_vec;
	rhsn_pkg::side_t  rad_side;

	logic             nrm_valid;
	logic [2:0][31:0] nrm_vec;
	rhsn_pkg::side_t  nrm_side;

	// Never stall: every stage advances each cycle.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// Origin registers; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rhsn_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
				rhsn_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
				rhsn_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Hit point and offset from the centre.
	rhsn_pos #(
		.FracBits(FracBits)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.hit      (hit),
		.origin   ({origin_z_q, origin_y_q, origin_x_q}),
		.out_valid(pos_valid),
		.vec      (pos_vec),
		.side     (pos_side)
	);

	// Strip the axial component for cylinders.
	rhsn_radial #(
		.FracBits(FracBits)
	) u_radial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pos_valid),
		.vec      (pos_vec),
		.side     (pos_side),
		.out_valid(rad_valid),
		.wvec     (rad_vec),
		.side_out (rad_side)
	);

	// Scale to unit length.
	rhsn_norm #(
		.FracBits(FracBits)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rad_valid),
		.wvec     (rad_vec),
		.side     (rad_side),
		.out_valid(nrm_valid),
		.norm     (nrm_vec),
		.side_out (nrm_side)
	);

	// Pick the normal by kind; zero everything for unknown kinds.
	always_comb begin
		res = '0;
		if (nrm_side.known) begin
			res.type_known = 1'b1;
			res.pos_x      = nrm_side.pos[0];
			res.pos_y      = nrm_side.pos[1];
			res.pos_z      = nrm_side.pos[2];
			if (nrm_side.plane) begin
				res.norm_x = nrm_side.axis[0];
				res.norm_y = nrm_side.axis[1];
				res.norm_z = nrm_side.axis[2];
			end else begin
				res.norm_x = nrm_vec[0];
				res.norm_y = nrm_vec[1];
				res.norm_z = nrm_vec[2];
			end
		end
	end

	assign done = nrm_valid;

endmodule

/* tb/ray_hit_surface_normal_tb.sv */
// Self-checking testbench for the ray hit point and surface normal pipeline.
`timescale 1ns / 100ps

module ray_hit_surface_normal_tb;

	localparam int  FRAC       = rhsn_pkg::FRAC_BITS_DEF;
	localparam int  DRAIN_WAIT = 80;    // longer than the pipeline depth
	localparam int  STALL_MAX  = 3000;  // cycles without any handshake before giving up
	localparam int  RAND_PHASE = 350;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	rhsn_pkg::hit_t  hit = '0;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	logic  [rhsn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic  [31:0] cfg_data = '0;
	logic  done;
	rhsn_pkg::res_t  res;

	// Origin as the block should now hold it
	longint org [3];

	rhsn_pkg::hit_t  pending_hits [$];
	rhsn_pkg::res_t  expected_res [$];
	int    mismatches = 0;
	int    idle_left = 0;
	bit    no_idle = 1'b0;
	int    quiet_cycles = 0;

	ray_hit_surface_normal uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .hit(hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .res(res)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned abs_val(longint v);
		return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
	endfunction

	// Exact product, magnitude truncated by the fraction width, sign restored
	function automatic longint fx_mul(longint a, longint b);
		bit neg;
		longint unsigned p;
		neg = (a < 0) != (b < 0);
		p = (abs_val(a) * abs_val(b)) >> FRAC;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// Scale to put the largest magnitude in [2^29, 2^30), then divide by the length
	function automatic void unit_vec(input longint v [3], output longint n [3]);
		longint unsigned m [3];
		longint unsigned mx;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs_val(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++)
				n[i] = 0;
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] << FRAC) / len;
			n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic rhsn_pkg::res_t hit_result(rhsn_pkg::hit_t h);
		rhsn_pkg::res_t r;
		longint d [3], c [3], a [3], p [3], v [3], n [3];
		longint t, s;
		r = '0;
		t = longint'({33'd0, h.distance});
		d = '{h.dir_x, h.dir_y, h.dir_z};
		c = '{h.center_x, h.center_y, h.center_z};
		a = '{h.axis_x, h.axis_y, h.axis_z};
		case (h.kind)
			rhsn_pkg::KIND_SPHERE, rhsn_pkg::KIND_PLANE, rhsn_pkg::KIND_CYL,
			rhsn_pkg::KIND_CYL_ALT: begin
				for (int i = 0; i < 3; i++)
					p[i] = sat_word(org[i] + fx_mul(d[i], t));
				if (h.kind == rhsn_pkg::KIND_PLANE) begin
					n = a;
				end else begin
					for (int i = 0; i < 3; i++)
						v[i] = p[i] - c[i];
					// Cylinders: strip the part along the axis, axis taken as given
					if (h.kind != rhsn_pkg::KIND_SPHERE) begin
						s = 0;
						for (int i = 0; i < 3; i++)
							s += fx_mul(v[i], a[i]);
						s = sat_word(s);
						for (int i = 0; i < 3; i++)
							v[i] -= fx_mul(a[i], s);
					end
					unit_vec(v, n);
				end
				r.pos_x = p[0][31:0];
				r.pos_y = p[1][31:0];
				r.pos_z = p[2][31:0];
				r.norm_x = n[0][31:0];
				r.norm_y = n[1][31:0];
				r.norm_z = n[2][31:0];
				r.type_known = 1'b1;
			end
			default: r = '0;  // unknown kind: everything zero
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
			2: return 32'($signed($urandom_range(0, 262144)) - 131072);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
		endcase
	endfunction

	function automatic rhsn_pkg::hit_t rand_hit();
		rhsn_pkg::hit_t h;
		h.kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		h.dir_x = rand_word();
		h.dir_y = rand_word();
		h.dir_z = rand_word();
		h.distance = ($urandom_range(0, 3) == 0) ? 31'($urandom)
			: 31'($urandom_range(0, 4194304));
		h.center_x = rand_word();
		h.center_y = rand_word();
		h.center_z = rand_word();
		// Half the time a unit axis along one direction, otherwise anything
		if ($urandom_range(0, 1) == 0) begin
			h.axis_x = '0;
			h.axis_y = '0;
			h.axis_z = '0;
			case ($urandom_range(0, 2))
				0: h.axis_x = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
				1: h.axis_y = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
				default: h.axis_z = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
			endcase
		end else begin
			h.axis_x = rand_word();
			h.axis_y = rand_word();
			h.axis_z = rand_word();
		end
		return h;
	endfunction

	function automatic rhsn_pkg::hit_t make_hit(logic [2:0] k, logic [31:0] dv,
			logic [30:0] t, logic [31:0] cv, logic [31:0] av);
		rhsn_pkg::hit_t h;
		h.kind = k;
		h.dir_x = dv; h.dir_y = -dv; h.dir_z = dv >>> 1;
		h.distance = t;
		h.center_x = cv; h.center_y = cv; h.center_z = -cv;
		h.axis_x = av; h.axis_y = '0; h.axis_z = '0;
		return h;
	endfunction

	// Write one origin register and track it in the predictor
	task automatic write_reg(rhsn_pkg::cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= rhsn_pkg::REG_ORIGIN_Z)
			org[idx] = longint'($signed(val));
	endtask

	// Hold until every request has come back and the pipeline has emptied
	task automatic drain();
		while (pending_hits.size() > 0 || expected_res.size() > 0 || start)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_origin(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		write_reg(rhsn_pkg::REG_ORIGIN_X, x);
		write_reg(rhsn_pkg::REG_ORIGIN_Y, y);
		write_reg(rhsn_pkg::REG_ORIGIN_Z, z);
	endtask

	task automatic random_phase(int count);
		repeat (count) pending_hits.push_back(rand_hit());
		drain();
	endtask

	initial begin
		org = '{0, 0, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset origin: every kind, field extremes
		for (int k = 0; k < 8; k++)
			pending_hits.push_back(make_hit(3'(k), 32'sd65536, 31'd131072,
				32'sd32768, 32'sd65536));
		// Zero-length vector: hit point lands on the centre
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_SPHERE, 32'sd0, 31'd0, 32'sd0,
			32'sd65536));
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_CYL, 32'sd0, 31'd0, 32'sd0,
			32'sd65536));
		// Radial part vanishes: point lies on the axis
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_CYL_ALT, 32'sd0, 31'd0, 32'sd0,
			32'sd0));
		// Saturating positions, both signs
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_SPHERE, 32'h7fff_ffff,
			31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_CYL, 32'h8000_0000, 31'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000));
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_PLANE, 32'hffff_ffff,
			31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		// Non-unit axis, used as it stands
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_CYL, 32'sd70000, 31'd65536,
			32'sd12345, 32'sd200000));
		pending_hits.push_back(make_hit(rhsn_pkg::KIND_CYL_ALT, 32'h5555_5555,
			31'h2aaa_aaaa, 32'haaaa_aaaa, 32'h0000_8000));
		drain();

		random_phase(RAND_PHASE);
		set_origin(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		random_phase(RAND_PHASE);
		set_origin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		// An index past the list must be dropped
		write_reg(rhsn_pkg::cfg_reg_t'(2'd3), 32'h1234_5678);
		random_phase(RAND_PHASE);
		set_origin($urandom, $urandom, $urandom);
		random_phase(RAND_PHASE);
		set_origin(32'sd65536, -32'sd131072, 32'sd0);
		no_idle = 1'b1;
		random_phase(RAND_PHASE);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_res.push_back(hit_result(hit));
			if (start && busy) begin
				// hold the request until it is taken
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_hits.size() > 0) begin
				if (!no_idle && $urandom_range(0, 5) == 0) begin
					idle_left = $urandom_range(0, 5);
					start <= 1'b0;
				end else begin
					hit <= pending_hits.pop_front();
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		rhsn_pkg::res_t want;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				report("unexpected result", res.pos_x, 32'd0);
			end else begin
				want = expected_res.pop_front();
				if (res.pos_x !== want.pos_x) report("pos_x", res.pos_x, want.pos_x);
				if (res.pos_y !== want.pos_y) report("pos_y", res.pos_y, want.pos_y);
				if (res.pos_z !== want.pos_z) report("pos_z", res.pos_z, want.pos_z);
				if (res.norm_x !== want.norm_x) report("norm_x", res.norm_x, want.norm_x);
				if (res.norm_y !== want.norm_y) report("norm_y", res.norm_y, want.norm_y);
				if (res.norm_z !== want.norm_z) report("norm_z", res.norm_z, want.norm_z);
				if (res.type_known !== want.type_known)
					report("type_known", 32'(res.type_known), 32'(want.type_known));
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
